/* hdl/sopca_pkg.sv */
// shared types and constants for the online pca block
package sopca_pkg;

    // datapath widths
    localparam int XW  = 16;  // input sample
    localparam int WW  = 24;  // basis weight, Q1.22
    localparam int MW  = 32;  // channel mean, 2^-26 V
    localparam int XCW = 24;  // centred sample, 2^-16 V
    localparam int YW  = 28;  // projection
    localparam int CW  = 29;  // per-component step coefficient
    localparam int RW  = 32;  // residual
    localparam int MAW = 30;  // lane multiplier operand a
    localparam int MBW = 33;  // lane multiplier operand b
    localparam int PW  = MAW + MBW;
    localparam int QW  = 25;  // renormalise quotient bits
    localparam int SW  = 32;  // square root width
    localparam int DW  = 56;  // divider remainder width
    localparam int OW  = 15;  // output component
    localparam int LRW = 25;
    localparam int MCW = 24;
    localparam int OSW = 16;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic signed [WW-1:0] W_ONE = 24'sh400000;
    localparam logic signed [WW-1:0] W_MAX = 24'sh7FFFFF;
    localparam logic signed [WW-1:0] W_MIN = 24'sh800000;
    localparam logic signed [OW-1:0] OUT_LIM = 15'sd10240;

    // reset values of the registers
    localparam logic [LRW-1:0] LRATE_RST  = 25'd192800;
    localparam logic [MCW-1:0] MCOEF_RST  = 24'd1195;
    localparam logic [OSW-1:0] OSCALE_RST = 16'd4096;

    // register map
    typedef enum logic [CFG_IW-1:0] {
        REG_CENTRE = 3'd0,
        REG_FREEZE = 3'd1,
        REG_LRATE  = 3'd2,
        REG_MCOEF  = 3'd3,
        REG_OSCALE = 3'd4
    } cfg_reg_t;

    // lane operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_MMUL,
        OP_MEAN,
        OP_XC,
        OP_PROJ,
        OP_RMUL,
        OP_RSUB,
        OP_UMUL,
        OP_UPD,
        OP_SQ,
        OP_DIVLD,
        OP_DIVSTEP,
        OP_WB
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     action;
        logic     centre;
        logic     zero_norm;
    } lane_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MMUL,
        ST_MEAN,
        ST_XC,
        ST_PROJ,
        ST_PSUM,
        ST_RMUL,
        ST_RSUB,
        ST_UMUL,
        ST_UPD,
        ST_SQ,
        ST_NSUM,
        ST_SQRT,
        ST_DIVLD,
        ST_DIV,
        ST_WB,
        ST_OMUL,
        ST_OSAT,
        ST_DONE
    } state_t;

endpackage

/* hdl/sopca_sqrt.sv */
// iterative integer square root, one result bit per cycle
module sopca_sqrt
    import sopca_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   radicand,
    output logic          busy,
    output logic [SW-1:0] root
);

    logic [63:0] n_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    // digit recurrence, bit walks down two places per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && bit_reg == 64'd1) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[SW-1:0];

endmodule

/* hdl/sopca_lane.sv */
// one channel lane: mean tracker, weight column, residual and divider
module sopca_lane
    import sopca_pkg::*;
#(
    parameter int NUM_COMPONENTS = 3,
    parameter int LANE           = 0,
    parameter int KW             = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lane_ctrl_t            ctrl,
    input  logic [KW-1:0]         comp_idx,
    input  logic signed [XW-1:0]  sample,
    input  logic [MCW-1:0]        mean_coef,
    input  logic signed [YW-1:0]  y_k,
    input  logic signed [CW-1:0]  coef_k,
    input  logic [SW-1:0]         root,
    output logic signed [PW-1:0]  prod
);

    localparam logic signed [PW-1:0] HALF22 = PW'(64'd2097152);
    localparam logic signed [PW-1:0] HALF20 = PW'(64'd524288);

    logic signed [WW-1:0]  w_reg [NUM_COMPONENTS];
    logic signed [MW-1:0]  mean_reg;
    logic signed [XW-1:0]  sample_reg;
    logic signed [MBW-1:0] diff_reg;
    logic signed [XCW-1:0] xc_reg;
    logic signed [RW-1:0]  res_reg;
    logic signed [WW-1:0]  v_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         den_reg;
    logic [QW-1:0]         q_reg;

    logic signed [WW-1:0]  w_k;
    logic signed [31:0]    x_full;
    logic signed [MBW-1:0] diff_c;
    logic signed [33:0]    xsum;
    logic signed [XCW-1:0] xc_next;
    logic signed [PW-1:0]  rnd22;
    logic signed [PW-1:0]  rnd20;
    logic signed [42:0]    delta;
    logic signed [43:0]    vsum;
    logic signed [WW-1:0]  v_next;
    logic [WW:0]           vneg;
    logic [WW-1:0]         mag;
    logic signed [WW-1:0]  w_next;
    logic signed [MAW-1:0] ma;
    logic signed [MBW-1:0] mb;
    logic signed [PW-1:0]  prod_next;

    assign w_k    = w_reg[comp_idx];
    assign x_full = {sample_reg, 16'b0};
    assign diff_c = MBW'(x_full) - MBW'(mean_reg);

    // centred or plain sample in 2^-16 V
    assign xsum    = 34'(diff_c) + 34'sd512;
    assign xc_next = ctrl.centre ? xsum[33:10] : {{2{sample_reg[XW-1]}}, sample_reg, 6'b0};

    // rounded product terms
    assign rnd22 = prod_reg + HALF22;
    assign rnd20 = prod_reg + HALF20;
    assign delta = rnd20[PW-1:20];
    assign vsum  = 44'(w_k) + 44'(delta);

    // hebbian update with weight saturation
    always_comb begin
        if (vsum > 44'(W_MAX)) begin
            v_next = W_MAX;
        end else if (vsum < 44'(W_MIN)) begin
            v_next = W_MIN;
        end else begin
            v_next = vsum[WW-1:0];
        end
    end

    assign vneg = -{v_reg[WW-1], v_reg};
    assign mag  = v_reg[WW-1] ? vneg[WW-1:0] : v_reg;

    // renormalised weight, zero for a zero norm, else clamped to the weight range
    always_comb begin
        if (ctrl.zero_norm) begin
            w_next = '0;
        end else if (q_reg[QW-1:WW-1] != '0) begin
            w_next = v_reg[WW-1] ? W_MIN : W_MAX;
        end else if (v_reg[WW-1]) begin
            w_next = -{1'b0, q_reg[WW-2:0]};
        end else begin
            w_next = {1'b0, q_reg[WW-2:0]};
        end
    end

    // multiplier operand select
    always_comb begin
        case (ctrl.op)
            OP_MMUL: begin
                ma = MAW'($signed({1'b0, mean_coef}));
                mb = diff_reg;
            end
            OP_PROJ: begin
                ma = MAW'(w_k);
                mb = MBW'(xc_reg);
            end
            OP_RMUL: begin
                ma = MAW'(y_k);
                mb = MBW'(w_k);
            end
            OP_UMUL: begin
                ma = MAW'(coef_k);
                mb = MBW'(res_reg);
            end
            OP_SQ: begin
                ma = MAW'(v_reg);
                mb = MBW'(v_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod_next = ma * mb;
    end

    // weight column and mean: reset and the reset action load the unit column and clear the mean
    always_ff @(posedge aclk) begin
        if (!aresetn || (ctrl.op == OP_LOAD && ctrl.action)) begin
            for (int k = 0; k < NUM_COMPONENTS; k++) begin
                w_reg[k] <= (k == LANE) ? W_ONE : '0;
            end
            mean_reg <= '0;
        end else begin
            if (ctrl.op == OP_MEAN && ctrl.centre) begin
                mean_reg <= mean_reg + prod_reg[55:24];
            end
            if (ctrl.op == OP_WB) begin
                w_reg[comp_idx] <= w_next;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: sample_reg <= sample;
            OP_DIFF: diff_reg <= diff_c;
            OP_XC: begin
                xc_reg  <= xc_next;
                res_reg <= RW'(xc_next);
            end
            OP_RSUB: res_reg <= res_reg - rnd22[53:22];
            OP_UPD:  v_reg <= v_next;
            OP_DIVLD: begin
                rem_reg <= {4'b0, mag, 28'b0} + DW'(root >> 1);
                den_reg <= {root, 24'b0};
            end
            OP_DIVSTEP: begin
                if (rem_reg >= den_reg) begin
                    rem_reg <= rem_reg - den_reg;
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end else begin
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
            end
            default: ;
        endcase
        if (ctrl.op == OP_MMUL || ctrl.op == OP_PROJ || ctrl.op == OP_RMUL ||
            ctrl.op == OP_UMUL || ctrl.op == OP_SQ) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* hdl/sanger_online_pca_top.sv */
// online pca by sanger's rule: lanes per channel, merge, sequencer
//
// Each input beat carries one sample per channel; the block answers with one
// result beat holding three components and a clip flag. The channels are
// handled by parallel lanes; a merge stage sums lane products for projections
// and norms, and a shared iterative square root serves the renormalisation.
// While learning, each component runs a weight update, the 32-step square root
// and the 25-step restoring divide in each lane; with the basis frozen these are
// skipped. An item waits in the done state while the previous result beat waits
// on m_ready. A new input beat is taken once the previous item has moved into
// the output register.
module sanger_online_pca_top
    import sopca_pkg::*;
#(
    parameter int NUM_CHANNELS   = 6,
    parameter int NUM_COMPONENTS = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic signed [XW-1:0] s_chan_a,
    input  logic signed [XW-1:0] s_chan_b,
    input  logic signed [XW-1:0] s_chan_c,
    input  logic signed [XW-1:0] s_chan_d,
    input  logic signed [XW-1:0] s_chan_e,
    input  logic signed [XW-1:0] s_chan_f,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [OW-1:0] m_comp_one,
    output logic signed [OW-1:0] m_comp_two,
    output logic signed [OW-1:0] m_comp_three,
    output logic                 m_clipped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    localparam int KW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(NUM_COMPONENTS - 1);
    localparam logic signed [PW-1:0] HALF22 = PW'(64'd2097152);
    localparam logic signed [53:0]   HALF24 = 54'sd8388608;
    localparam logic signed [53:0]   HALF18 = 54'sd131072;

    state_t state_reg, state_next;
    lane_ctrl_t ctrl;

    logic                 centre_reg;
    logic                 freeze_reg;
    logic [LRW-1:0]       lrate_reg;
    logic [MCW-1:0]       mcoef_reg;
    logic [OSW-1:0]       oscale_reg;

    logic [KW-1:0]        k_reg;
    logic                 post_reg;
    logic [4:0]           cnt_reg;
    logic                 action_reg;
    logic                 zero_reg;
    logic signed [YW-1:0] y_reg [NUM_COMPONENTS];
    logic signed [YW-1:0] ypost_reg;
    logic signed [CW-1:0] coef_reg;
    logic signed [53:0]   cprod_reg;
    logic signed [OW-1:0] comp_reg [3];
    logic                 clip_reg;

    logic                 m_valid_reg;
    logic signed [OW-1:0] m_one_reg;
    logic signed [OW-1:0] m_two_reg;
    logic signed [OW-1:0] m_three_reg;
    logic                 m_clip_reg;

    logic signed [XW-1:0] chan [6];
    logic signed [PW-1:0] prods [NUM_CHANNELS];
    logic signed [PW-1:0] psum;
    logic signed [PW-1:0] ysum;
    logic signed [YW-1:0] y_val;
    logic [50:0]          n2;
    logic signed [25:0]   ma2;
    logic signed [YW-1:0] mb2;
    logic signed [53:0]   csum;
    logic signed [53:0]   osum;
    logic signed [35:0]   o_val;
    logic                 sq_busy;
    logic [SW-1:0]        sq_root;
    logic                 in_beat;
    logic                 out_free;

    assign chan[0] = s_chan_a;
    assign chan[1] = s_chan_b;
    assign chan[2] = s_chan_c;
    assign chan[3] = s_chan_d;
    assign chan[4] = s_chan_e;
    assign chan[5] = s_chan_f;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg <= 1'b1;
            freeze_reg <= 1'b0;
            lrate_reg  <= LRATE_RST;
            mcoef_reg  <= MCOEF_RST;
            oscale_reg <= OSCALE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTRE: centre_reg <= cfg_data[0];
                REG_FREEZE: freeze_reg <= cfg_data[0];
                REG_LRATE:  lrate_reg  <= cfg_data[LRW-1:0];
                REG_MCOEF:  mcoef_reg  <= cfg_data[MCW-1:0];
                REG_OSCALE: oscale_reg <= cfg_data[OSW-1:0];
                default: ;
            endcase
        end
    end

    // channel lanes
    for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_lane
        sopca_lane #(
            .NUM_COMPONENTS(NUM_COMPONENTS),
            .LANE          (n),
            .KW            (KW)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .comp_idx (k_reg),
            .sample   (chan[n]),
            .mean_coef(mcoef_reg),
            .y_k      (y_reg[k_reg]),
            .coef_k   (coef_reg),
            .root     (sq_root),
            .prod     (prods[n])
        );
    end

    // merge: sum of lane products
    always_comb begin
        psum = '0;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            psum = psum + prods[n];
        end
    end

    assign ysum  = psum + HALF22;
    assign y_val = ysum[49:22];
    assign n2    = psum[50:0];

    sopca_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_NSUM),
        .radicand({1'b0, n2, 12'b0}),
        .busy    (sq_busy),
        .root    (sq_root)
    );

    // merge multiplier: step size or output gain times projection
    assign ma2   = (state_reg == ST_RMUL) ? 26'($signed({1'b0, lrate_reg}))
                                          : 26'($signed({1'b0, oscale_reg}));
    assign mb2   = (state_reg == ST_RMUL) ? y_reg[k_reg] : ypost_reg;
    assign csum  = cprod_reg + HALF24;
    assign osum  = cprod_reg + HALF18;
    assign o_val = osum[53:18];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MMUL;
            ST_MMUL:  state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_XC;
            ST_XC:    state_next = ST_PROJ;
            ST_PROJ:  state_next = ST_PSUM;
            ST_PSUM: begin
                if (post_reg) begin
                    state_next = ST_OMUL;
                end else if (k_reg != K_LAST) begin
                    state_next = ST_PROJ;
                end else if (freeze_reg) begin
                    state_next = ST_PROJ;
                end else begin
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL:  state_next = ST_RSUB;
            ST_RSUB:  state_next = ST_UMUL;
            ST_UMUL:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_NSUM;
            ST_NSUM:  state_next = ST_SQRT;
            ST_SQRT:  if (!sq_busy) state_next = ST_DIVLD;
            ST_DIVLD: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == 5'(QW - 1)) state_next = ST_WB;
            ST_WB:    state_next = (k_reg == K_LAST) ? ST_PROJ : ST_RMUL;
            ST_OMUL:  state_next = ST_OSAT;
            ST_OSAT:  state_next = (k_reg == K_LAST) ? ST_DONE : ST_PROJ;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // lane control
    always_comb begin
        ctrl.action    = s_action;
        ctrl.centre    = centre_reg;
        ctrl.zero_norm = zero_reg;
        unique case (state_reg)
            ST_IDLE:  ctrl.op = in_beat ? OP_LOAD : OP_NONE;
            ST_DIFF:  ctrl.op = OP_DIFF;
            ST_MMUL:  ctrl.op = OP_MMUL;
            ST_MEAN:  ctrl.op = OP_MEAN;
            ST_XC:    ctrl.op = OP_XC;
            ST_PROJ:  ctrl.op = OP_PROJ;
            ST_RMUL:  ctrl.op = OP_RMUL;
            ST_RSUB:  ctrl.op = OP_RSUB;
            ST_UMUL:  ctrl.op = OP_UMUL;
            ST_UPD:   ctrl.op = OP_UPD;
            ST_SQ:    ctrl.op = OP_SQ;
            ST_DIVLD: ctrl.op = OP_DIVLD;
            ST_DIV:   ctrl.op = OP_DIVSTEP;
            ST_WB:    ctrl.op = OP_WB;
            default:  ctrl.op = OP_NONE;
        endcase
    end

    // sequencer state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            post_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    k_reg    <= '0;
                    post_reg <= 1'b0;
                end
                ST_PSUM: begin
                    if (!post_reg) begin
                        if (k_reg != K_LAST) begin
                            k_reg <= k_reg + 1'b1;
                        end else begin
                            k_reg    <= '0;
                            post_reg <= freeze_reg;
                        end
                    end
                end
                ST_DIVLD: cnt_reg <= '0;
                ST_DIV:   cnt_reg <= cnt_reg + 5'd1;
                ST_WB: begin
                    if (k_reg != K_LAST) begin
                        k_reg <= k_reg + 1'b1;
                    end else begin
                        k_reg    <= '0;
                        post_reg <= 1'b1;
                    end
                end
                ST_OSAT: if (k_reg != K_LAST) k_reg <= k_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // merge datapath
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            action_reg <= s_action;
            clip_reg   <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                comp_reg[j] <= '0;
            end
        end
        case (state_reg)
            ST_PSUM: begin
                if (post_reg) begin
                    ypost_reg <= y_val;
                end else begin
                    y_reg[k_reg] <= y_val;
                end
            end
            ST_RMUL, ST_OMUL: cprod_reg <= ma2 * mb2;
            ST_RSUB: coef_reg <= csum[52:24];
            ST_NSUM: zero_reg <= (n2 == '0);
            ST_OSAT: begin
                if (o_val > 36'(OUT_LIM)) begin
                    comp_reg[2'(k_reg)] <= OUT_LIM;
                    clip_reg            <= 1'b1;
                end else if (o_val < -36'(OUT_LIM)) begin
                    comp_reg[2'(k_reg)] <= -OUT_LIM;
                    clip_reg            <= 1'b1;
                end else begin
                    comp_reg[2'(k_reg)] <= o_val[OW-1:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_one_reg   <= comp_reg[0];
            m_two_reg   <= comp_reg[1];
            m_three_reg <= comp_reg[2];
            m_clip_reg  <= clip_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_comp_one   = m_one_reg;
    assign m_comp_two   = m_two_reg;
    assign m_comp_three = m_three_reg;
    assign m_clipped    = m_clip_reg;

    // checks
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside done");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_comp_one <= OUT_LIM && m_comp_one >= -OUT_LIM &&
                     m_comp_two <= OUT_LIM && m_comp_two >= -OUT_LIM &&
                     m_comp_three <= OUT_LIM && m_comp_three >= -OUT_LIM))
        else $error("component out of clamp range");

    a_sqrt_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_busy |-> state_reg == ST_SQRT)
        else $error("square root busy outside its state");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> state_reg == ST_DIFF && !action_reg == !$past(s_action))
        else $error("accepted beat did not start processing");

endmodule
